// ----- design/lzss_pkg.sv -----
// Shared constants, types and codes of the LZSS stream decompressor.
package lzss_pkg;

  localparam int WIN_AW = 12;
  localparam int WIN_DEPTH = 1 << WIN_AW;
  localparam int CNT_W = 24;
  localparam int LEN_W = 5;

  localparam logic [WIN_AW-1:0] START_POS = 12'hFEE;
  localparam logic [LEN_W-1:0] MATCH_MIN = 5'd3;

  // Parse phase codes
  localparam logic [1:0] PH_FLAG = 2'd0;
  localparam logic [1:0] PH_TOKEN = 2'd1;
  localparam logic [1:0] PH_MATCH2 = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_DAT  = 4'b0100,
    S_EMIT = 4'b1000
  } lzss_state_t;

  // One result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       run_last;
    logic       stream_done;
  } lzss_res_t;

  // Window access request from the sequencer
  typedef struct packed {
    logic              clr;
    logic              wr_en;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [WIN_AW-1:0] rd_addr;
  } lzss_win_req_t;

endpackage

// ----- design/lzss_ifs.sv -----
// Channel interfaces: compressed input, decoded output, configuration write.
interface lzss_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       stream_start;
  logic       in_last;
  modport source (output valid, in_byte, stream_start, in_last, input ready);
  modport sink (input valid, in_byte, stream_start, in_last, output ready);
endinterface

interface lzss_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       run_last;
  logic       stream_done;
  modport source (output valid, out_byte, out_valid, run_last, stream_done, input ready);
  modport sink (input valid, out_byte, out_valid, run_last, stream_done, output ready);
endinterface

interface lzss_cfg_if;
  logic        valid;
  logic        ready;
  logic [23:0] output_limit;
  modport source (output valid, output_limit, input ready);
  modport sink (input valid, output_limit, output ready);
endinterface

// ----- design/lzss_stream_decompressor_unit.sv -----
// Top level of the LZSS stream decompressor: channels, limit register, output register.
//
//  Channel  Dir  Payload                                      Handshake
//  in_ch    in   in_byte[7:0], stream_start, in_last          valid/ready
//  out_ch   out  out_byte[7:0], out_valid, run_last,          valid/ready
//                stream_done
//  cfg_ch   in   output_limit[23:0]                           valid/ready, always ready
//
// Flag bytes and first match bytes are consumed in the idle state; a literal or end marker
// passes through the emit state into the output register. A match copies 3 to 18 bytes,
// fewer if the output limit ends it, each byte as a registered window read (read state),
// then emit and write back (data state). Reset is synchronous, active low; the
// window needs no clearing pass, since a fill count makes unwritten entries read as zero.
// A stalled output register holds the sequencer; input is ready only when it is idle.
module lzss_stream_decompressor_unit (
  input logic        clk,
  input logic        rst_n,
  lzss_in_if.sink    in_ch,
  lzss_out_if.source out_ch,
  lzss_cfg_if.sink   cfg_ch
);
  import lzss_pkg::*;

  logic [CNT_W-1:0] limit_r;
  logic             out_vld_r, out_vld_nxt;
  lzss_res_t        out_pl_r;
  logic             res_valid;
  logic             res_ready;
  lzss_res_t        res;
  lzss_win_req_t    win_req;
  logic [7:0]       win_rdata;

  // Configuration is always taken
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= '0;
    end else if (cfg_ch.valid) begin
      limit_r <= cfg_ch.output_limit;
    end
  end

  lzss_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_byte      (in_ch.in_byte),
    .stream_start (in_ch.stream_start),
    .in_last      (in_ch.in_last),
    .limit        (limit_r),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res),
    .win_req      (win_req),
    .win_rdata    (win_rdata)
  );

  lzss_window u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (win_req),
    .rd_data (win_rdata)
  );

  // Output register: load a new result whenever the current one leaves or the slot is empty
  assign res_ready = !out_vld_r || out_ch.ready;

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (res_ready) begin
      out_vld_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_pl_r <= res;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.out_byte    = out_pl_r.out_byte;
  assign out_ch.out_valid   = out_pl_r.out_valid;
  assign out_ch.run_last    = out_pl_r.run_last;
  assign out_ch.stream_done = out_pl_r.stream_done;

endmodule

// ----- design/lzss_window.sv -----
// History window: 4096-byte RAM with write pointer and fill count for zero reads.
module lzss_window (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lzss_pkg::lzss_win_req_t req,
  output logic [7:0]            rd_data
);
  import lzss_pkg::*;

  logic [7:0]        mem [WIN_DEPTH];
  logic [WIN_AW-1:0] wpos_r, wpos_nxt;
  logic [WIN_AW:0]   fill_r, fill_nxt;
  logic [7:0]        rd_q_r;
  logic              rd_ok_r;
  logic [WIN_AW-1:0] rd_off;
  logic              rd_ok;

  // An entry is written iff its distance from the start position is below the fill count
  assign rd_off = req.rd_addr - START_POS;
  assign rd_ok = fill_r[WIN_AW] || (rd_off < fill_r[WIN_AW-1:0]);

  always_comb begin
    wpos_nxt = wpos_r;
    fill_nxt = fill_r;
    if (req.clr) begin
      wpos_nxt = START_POS;
      fill_nxt = '0;
    end else if (req.wr_en) begin
      wpos_nxt = wpos_r + 1'b1;
      if (!fill_r[WIN_AW]) begin
        fill_nxt = fill_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wpos_r <= START_POS;
      fill_r <= '0;
    end else begin
      wpos_r <= wpos_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en && !req.clr) begin
      mem[wpos_r] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_q_r  <= mem[req.rd_addr];
      rd_ok_r <= rd_ok;
    end
  end

  assign rd_data = rd_ok_r ? rd_q_r : 8'h00;

endmodule

// ----- design/lzss_seq.sv -----
// Token parser and copy sequencer: one window byte per read/emit pair.
module lzss_seq (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [7:0]              in_byte,
  input  logic                    stream_start,
  input  logic                    in_last,
  input  logic [lzss_pkg::CNT_W-1:0] limit,
  output logic                    res_valid,
  input  logic                    res_ready,
  output lzss_pkg::lzss_res_t     res,
  output lzss_pkg::lzss_win_req_t win_req,
  input  logic [7:0]              win_rdata
);
  import lzss_pkg::*;

  lzss_state_t       st_r, st_nxt;
  logic [1:0]        phase_r, phase_nxt;
  logic [8:0]        flags_r, flags_nxt;
  logic [7:0]        low_r, low_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              fin_r, fin_nxt;
  logic [WIN_AW-1:0] rd_addr_r, rd_addr_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic              last_r, last_nxt;
  lzss_res_t         res_r, res_nxt;

  logic              e_fin;
  logic [1:0]        e_phase;
  logic [8:0]        e_flags;
  logic [CNT_W-1:0]  e_cnt;
  logic [CNT_W-1:0]  cnt_inc;
  logic [8:0]        tk_flags;
  logic              hit;
  logic              stop;
  lzss_res_t         marker;
  lzss_res_t         dat_res;

  // State as seen by this item once a stream start has been applied
  assign e_fin   = stream_start ? 1'b0 : fin_r;
  assign e_phase = stream_start ? PH_FLAG : phase_r;
  assign e_flags = stream_start ? 9'd0 : flags_r;
  assign e_cnt   = (stream_start && st_r == S_IDLE) ? '0 : cnt_r;
  assign cnt_inc = e_cnt + 1'b1;
  assign hit     = cnt_inc >= limit;
  assign tk_flags = e_flags >> 1;
  assign stop    = (len_r == LEN_W'(1)) || hit;

  assign marker  = '{out_byte: 8'h00, out_valid: 1'b0, run_last: 1'b1, stream_done: 1'b1};
  // Only the final byte of a copy reports the stream as done
  assign dat_res = '{out_byte: win_rdata, out_valid: 1'b1, run_last: stop,
                     stream_done: stop && (hit || last_r)};

  assign in_ready  = (st_r == S_IDLE);
  assign res_valid = (st_r == S_DAT) || (st_r == S_EMIT);
  assign res       = (st_r == S_DAT) ? dat_res : res_r;

  always_comb begin
    st_nxt      = st_r;
    phase_nxt   = phase_r;
    flags_nxt   = flags_r;
    low_nxt     = low_r;
    cnt_nxt     = cnt_r;
    fin_nxt     = fin_r;
    rd_addr_nxt = rd_addr_r;
    len_nxt     = len_r;
    last_nxt    = last_r;
    res_nxt     = res_r;
    win_req     = '{clr: 1'b0, wr_en: 1'b0, wr_data: 8'h00, rd_en: 1'b0, rd_addr: rd_addr_r};
    unique case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          if (stream_start) begin
            win_req.clr = 1'b1;
            fin_nxt     = 1'b0;
            cnt_nxt     = '0;
            phase_nxt   = PH_FLAG;
            flags_nxt   = '0;
            low_nxt     = '0;
          end
          if (!e_fin) begin
            if (e_cnt >= limit) begin
              fin_nxt = 1'b1;
              res_nxt = marker;
              st_nxt  = S_EMIT;
            end else if (e_phase == PH_FLAG || e_flags <= 9'd1) begin
              flags_nxt = {1'b1, in_byte};
              phase_nxt = PH_TOKEN;
              if (in_last) begin
                fin_nxt = 1'b1;
                res_nxt = marker;
                st_nxt  = S_EMIT;
              end
            end else if (e_phase == PH_TOKEN && e_flags[0]) begin
              // literal: store and emit
              win_req.wr_en   = 1'b1;
              win_req.wr_data = in_byte;
              cnt_nxt   = cnt_inc;
              flags_nxt = tk_flags;
              phase_nxt = (tk_flags <= 9'd1) ? PH_FLAG : PH_TOKEN;
              fin_nxt   = hit || in_last;
              res_nxt   = '{out_byte: in_byte, out_valid: 1'b1, run_last: 1'b1,
                            stream_done: hit || in_last};
              st_nxt    = S_EMIT;
            end else if (e_phase == PH_TOKEN) begin
              low_nxt   = in_byte;
              phase_nxt = PH_MATCH2;
              if (in_last) begin
                fin_nxt = 1'b1;
                res_nxt = marker;
                st_nxt  = S_EMIT;
              end
            end else begin
              // second match byte: start the copy
              rd_addr_nxt = {in_byte[7:4], low_r};
              len_nxt     = {1'b0, in_byte[3:0]} + MATCH_MIN;
              last_nxt    = in_last;
              flags_nxt   = tk_flags;
              phase_nxt   = (tk_flags <= 9'd1) ? PH_FLAG : PH_TOKEN;
              st_nxt      = S_RD;
            end
          end
        end
      end
      S_RD: begin
        win_req.rd_en = 1'b1;
        st_nxt        = S_DAT;
      end
      S_DAT: begin
        if (res_ready) begin
          win_req.wr_en   = 1'b1;
          win_req.wr_data = win_rdata;
          cnt_nxt     = cnt_inc;
          rd_addr_nxt = rd_addr_r + 1'b1;
          len_nxt     = len_r - 1'b1;
          if (stop) begin
            fin_nxt = hit || last_r;
            st_nxt  = S_IDLE;
          end else begin
            st_nxt = S_RD;
          end
        end
      end
      S_EMIT: begin
        if (res_ready) begin
          st_nxt = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      phase_r <= PH_FLAG;
      flags_r <= '0;
      low_r   <= '0;
      cnt_r   <= '0;
      fin_r   <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      phase_r <= phase_nxt;
      flags_r <= flags_nxt;
      low_r   <= low_nxt;
      cnt_r   <= cnt_nxt;
      fin_r   <= fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r <= rd_addr_nxt;
    len_r     <= len_nxt;
    last_r    <= last_nxt;
    res_r     <= res_nxt;
  end

  // A finished stream swallows bytes without a stream start
  a_fin_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_IDLE && in_valid && fin_r && !stream_start) |=> st_r == S_IDLE)
    else $error("byte after finish started work");

  // A copy in flight always has bytes left
  a_len_live: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_RD || st_r == S_DAT) |-> len_r != '0)
    else $error("copy running with zero length");

  // A stalled copy byte holds the sequencer
  a_dat_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_DAT && !res_ready) |=> st_r == S_DAT)
    else $error("copy advanced without output slot");

endmodule
